### rtl/fdr_pkg.sv
package fdr_pkg;

    localparam int TABLE_DEPTH = 16;
    // Slot number width; a one-slot table still carries one bit.
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ACTIVE_W    = 5;
    localparam int ENTRY_IDX_W = 4;
    // Common width for slot-number compares against the index field and the limit.
    localparam int CMP_W       = (IDX_W > ACTIVE_W) ? IDX_W : ACTIVE_W;

    localparam int OWNER_W = 32;
    localparam int CLASS_W = 2;
    localparam int DSCP_W  = 6;
    localparam int TOS_W   = 8;
    localparam int PRIO_W  = 4;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [PRIO_W-1:0] PRIO_FAST = 4'd7;
    localparam logic [PRIO_W-1:0] PRIO_MID  = 4'd0;
    localparam logic [PRIO_W-1:0] PRIO_SLOW = 4'd1;

    typedef enum logic {
        OP_CLASSIFY = 1'b0,
        OP_WRITE    = 1'b1
    } fdr_op_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_FAST = 2'd0,
        CLS_MID  = 2'd1,
        CLS_SLOW = 2'd2,
        CLS_NONE = 2'd3
    } fdr_class_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 1'b0,
        CFG_ACTIVE = 1'b1
    } fdr_cfg_t;

    // One word as it walks down the row of slots.
    typedef struct packed {
        fdr_op_t                 opcode;
        logic [ENTRY_IDX_W-1:0]  entry_index;
        logic [OWNER_W-1:0]      entry_owner;
        fdr_class_t              entry_class;
        logic [DSCP_W-1:0]       entry_dscp;
        logic                    entry_dscp_valid;
        logic [OWNER_W-1:0]      flow_owner;
        logic [TOS_W-1:0]        tos;
        logic [PRIO_W-1:0]       prio;
        logic                    matched;
    } fdr_word_t;

    // Control shared by every slot.
    typedef struct packed {
        logic                 advance;
        logic                 enable;
        logic [ACTIVE_W-1:0]  active_entries;
    } fdr_ctrl_t;

endpackage

### rtl/fdr_cell.sv
module fdr_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fdr_pkg::fdr_ctrl_t            ctrl,
    input  logic [fdr_pkg::IDX_W-1:0]     cell_idx,
    input  logic                          in_valid,
    input  fdr_pkg::fdr_word_t            in_word,
    output logic                          out_valid,
    output fdr_pkg::fdr_word_t            out_word
);
    import fdr_pkg::*;

    logic [OWNER_W-1:0] owner_reg, owner_next;
    fdr_class_t         class_reg, class_next;
    logic [DSCP_W-1:0]  dscp_reg, dscp_next;
    logic               dval_reg, dval_next;
    logic               valid_reg;
    fdr_word_t          word_reg, word_next;

    logic [CMP_W-1:0]   slot_num;
    logic               slot_active;
    logic               slot_written;
    logic               hit;

    assign slot_num     = CMP_W'(cell_idx);
    assign slot_active  = slot_num < CMP_W'(ctrl.active_entries);
    assign slot_written = in_valid && (in_word.opcode == OP_WRITE)
                          && (CMP_W'(in_word.entry_index) == slot_num);
    assign hit = in_valid && (in_word.opcode == OP_CLASSIFY) && !in_word.matched
                 && ctrl.enable && slot_active && (owner_reg != '0)
                 && (owner_reg == in_word.flow_owner);

    always_comb begin
        owner_next = owner_reg;
        class_next = class_reg;
        dscp_next  = dscp_reg;
        dval_next  = dval_reg;
        if (slot_written) begin
            owner_next = in_word.entry_owner;
            class_next = in_word.entry_class;
            dscp_next  = in_word.entry_dscp;
            dval_next  = in_word.entry_dscp_valid;
        end

        word_next = in_word;
        if (hit) begin
            word_next.matched = 1'b1;
            case (class_reg)
                CLS_FAST: word_next.prio = PRIO_FAST;
                CLS_MID:  word_next.prio = PRIO_MID;
                CLS_SLOW: word_next.prio = PRIO_SLOW;
                default:  word_next.prio = in_word.prio;
            endcase
            if (dval_reg) begin
                word_next.tos = {dscp_reg, in_word.tos[1:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_reg <= '0;
            class_reg <= CLS_NONE;
            dscp_reg  <= '0;
            dval_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else if (ctrl.advance) begin
            owner_reg <= owner_next;
            class_reg <= class_next;
            dscp_reg  <= dscp_next;
            dval_reg  <= dval_next;
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### rtl/flow_priority_dscp_remarker.sv
// Each word passes through the TABLE_DEPTH slot registers of the row, one slot per cycle while the
// row is not stalled; m_tvalid rises once the word is held in the last slot's register.
// Throughput: one word per cycle; every slot of the row advances together on each cycle
// in which the row is not stalled.
// A stalled output holds the whole row; s_tready follows the row's advance signal.
// Reset (aresetn low, synchronous) clears every slot to owner 0, class none, no DSCP,
// and sets enable and active_entries to 0.
module flow_priority_dscp_remarker (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input word
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] entry_index, [35:4] entry_owner, [37:36] entry_class,
    // [43:38] entry_dscp, [44] entry_dscp_valid, [76:45] flow_owner,
    // [84:77] packet_tos, [88:85] packet_priority, [95:89] zero
    input  logic [fdr_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,   // [0] opcode
    // Result word
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] new_priority, [11:4] new_tos, [12] matched, [15:13] zero
    output logic [fdr_pkg::M_TDATA_W-1:0]       m_tdata,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fdr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fdr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fdr_pkg::*;

    logic                 enable_reg, enable_next;
    logic [ACTIVE_W-1:0]  active_reg, active_next;

    fdr_ctrl_t  ctrl;
    fdr_word_t  in_word;
    logic       stage_valid [TABLE_DEPTH+1];
    fdr_word_t  stage_word  [TABLE_DEPTH+1];
    fdr_word_t  last_word;
    logic       advance;

    // Config registers are always ready; write them only while the row is idle.
    assign cfg_ready = 1'b1;

    always_comb begin
        enable_next = enable_reg;
        active_next = active_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ENABLE: enable_next = cfg_data[0];
                CFG_ACTIVE: active_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            active_reg <= '0;
        end else begin
            enable_reg <= enable_next;
            active_reg <= active_next;
        end
    end

    // Unpack the input word.
    always_comb begin
        in_word                  = '0;
        in_word.opcode           = fdr_op_t'(s_tuser);
        in_word.entry_index      = s_tdata[3:0];
        in_word.entry_owner      = s_tdata[35:4];
        in_word.entry_class      = fdr_class_t'(s_tdata[37:36]);
        in_word.entry_dscp       = s_tdata[43:38];
        in_word.entry_dscp_valid = s_tdata[44];
        in_word.flow_owner       = s_tdata[76:45];
        in_word.tos              = s_tdata[84:77];
        in_word.prio             = s_tdata[88:85];
        in_word.matched          = 1'b0;
    end

    // Advance the whole row unless a finished result is waiting at the output and m_tready is low.
    assign advance  = !stage_valid[TABLE_DEPTH] || m_tready;
    assign s_tready = advance;

    assign ctrl.advance        = advance;
    assign ctrl.enable         = enable_reg;
    assign ctrl.active_entries = active_reg;

    assign stage_valid[0] = s_tvalid;
    assign stage_word[0]  = in_word;

    // Row of slots: slot i holds table entry i and checks each passing word.
    // Earlier words are always further down the row, so writes and lookups
    // keep the order of arrival.
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        fdr_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .cell_idx  (IDX_W'(i)),
            .in_valid  (stage_valid[i]),
            .in_word   (stage_word[i]),
            .out_valid (stage_valid[i+1]),
            .out_word  (stage_word[i+1])
        );
    end

    assign last_word = stage_word[TABLE_DEPTH];
    assign m_tvalid  = stage_valid[TABLE_DEPTH];

    // Drop the payload of write words: their result is all zero.
    always_comb begin
        m_tdata = '0;
        if (last_word.opcode == OP_CLASSIFY) begin
            m_tdata[3:0]  = last_word.prio;
            m_tdata[11:4] = last_word.tos;
            m_tdata[12]   = last_word.matched;
        end
    end

    // A write word always leaves with an all-zero result.
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && last_word.opcode == OP_WRITE) |-> (m_tdata == '0))
        else $error("write word produced a nonzero result");

    // A match needs remarking on and at least one active slot.
    a_match_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[12]) |-> (enable_reg && (active_reg != '0)))
        else $error("match reported with remarking off or no active slots");

    // An accepted word enters the first slot on the next cycle.
    a_enter_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> stage_valid[1])
        else $error("accepted word did not enter the row");

    // A stalled result word holds steady until it is taken.
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

endmodule

### dv/flow_priority_dscp_remarker_test.sv
module flow_priority_dscp_remarker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fdr_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    // This is well above the longest planned receiver hold.
    localparam int HANG_LIMIT    = 2000;
    // The block is a 16-slot row; DRAIN_CYCLES is the wait after the last result.
    localparam int DRAIN_CYCLES  = 2 * TABLE_DEPTH + 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 190;
    localparam int POOL_SIZE     = 8;

    // One expected or observed result word.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TOS_W-1:0]  tos;
        logic              matched;
    } remark_t;

    // Shadow copy of the flow table and registers; predicts one result per
    // accepted input word and checks results in order.
    class remark_tracker;
        logic [OWNER_W-1:0]  owner_slot [TABLE_DEPTH];
        fdr_class_t          class_slot [TABLE_DEPTH];
        logic [DSCP_W-1:0]   dscp_slot  [TABLE_DEPTH];
        logic                dscp_on    [TABLE_DEPTH];
        logic                remark_on;
        logic [ACTIVE_W-1:0] active_count;
        remark_t             pending_marks [$];
        int                  errors;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                owner_slot[i] = '0;
                class_slot[i] = CLS_NONE;
                dscp_slot[i]  = '0;
                dscp_on[i]    = 1'b0;
            end
            remark_on    = 1'b0;
            active_count = '0;
            errors       = 0;
        endfunction

        function void set_reg(fdr_cfg_t idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ENABLE)
                remark_on = data[0];
            else
                active_count = data[ACTIVE_W-1:0];
        endfunction

        function void note_word(fdr_op_t op, logic [S_TDATA_W-1:0] data);
            logic [ENTRY_IDX_W-1:0] slot;
            logic [OWNER_W-1:0]     flow_id;
            int                     limit;
            bit                     found;
            remark_t                mark;
            slot    = data[3:0];
            flow_id = data[76:45];
            mark.prio    = data[88:85];
            mark.tos     = data[84:77];
            mark.matched = 1'b0;
            found        = 0;
            if (op == OP_WRITE) begin
                // Writes land whether or not remarking is on; result is all zero.
                if (int'(slot) < TABLE_DEPTH) begin
                    owner_slot[slot] = data[35:4];
                    class_slot[slot] = fdr_class_t'(data[37:36]);
                    dscp_slot[slot]  = data[43:38];
                    dscp_on[slot]    = data[44];
                end
                mark = '0;
            end else if (remark_on) begin
                // Clamp the active count to the table depth.
                limit = (int'(active_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
                for (int i = 0; i < limit; i++) begin
                    if (!found && owner_slot[i] != '0 && owner_slot[i] == flow_id) begin
                        found        = 1;
                        mark.matched = 1'b1;
                        case (class_slot[i])
                            CLS_FAST: mark.prio = PRIO_FAST;
                            CLS_MID:  mark.prio = PRIO_MID;
                            CLS_SLOW: mark.prio = PRIO_SLOW;
                            default:  mark.prio = mark.prio;
                        endcase
                        // Replace the DSCP bits, keep the two ECN bits.
                        if (dscp_on[i])
                            mark.tos = {dscp_slot[i], mark.tos[1:0]};
                    end
                end
            end
            pending_marks.push_back(mark);
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] data);
            remark_t want;
            remark_t got;
            got.prio    = data[3:0];
            got.tos     = data[11:4];
            got.matched = data[12];
            if (pending_marks.size() == 0) begin
                $display("%0t: result with nothing pending: expected none, got %h", $time, data);
                errors++;
            end else begin
                want = pending_marks.pop_front();
                if (got.prio != want.prio) begin
                    $display("%0t: new_priority expected %0d got %0d", $time, want.prio, got.prio);
                    errors++;
                end
                if (got.tos != want.tos) begin
                    $display("%0t: new_tos expected %h got %h", $time, want.tos, got.tos);
                    errors++;
                end
                if (got.matched != want.matched) begin
                    $display("%0t: matched expected %0d got %0d", $time,
                             want.matched, got.matched);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_marks.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    remark_tracker         tracker;
    int                    words_in;
    int                    idle_cycles;
    logic [OWNER_W-1:0]    owner_pool [POOL_SIZE];
    bit                    burst_phase;

    flow_priority_dscp_remarker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock, first rising edge at 5 ns.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sample both channels at the rising edge: check the result word first,
    // then record the accepted input word. Any handshake clears the hang count.
    always @(posedge aclk) begin
        bit moved;
        moved = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tracker.check_word(m_tdata);
                moved = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                tracker.note_word(fdr_op_t'(s_tuser), s_tdata);
                words_in <= words_in + 1;
                moved    = 1'b1;
            end
            if (cfg_valid && cfg_ready)
                moved = 1'b1;
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: bail out if nothing moves for too long.
    initial begin
        while (idle_cycles < HANG_LIMIT)
            @(posedge aclk);
        $display("FAIL");
        $finish;
    end

    // Receiver: mostly short ready runs and short stalls, some long stalls and long ready runs.
    // Once, after a few hundred words, hold off long enough to back up the whole row.
    initial begin
        int  stretch;
        bit  ready_phase;
        bit  pressure_done;
        int  pick;
        stretch       = 0;
        ready_phase   = 1'b0;
        pressure_done = 1'b0;
        m_tready      = 1'b0;
        forever begin
            @(negedge aclk);
            if (!pressure_done && words_in >= 300) begin
                pressure_done = 1'b1;
                ready_phase   = 1'b0;
                stretch       = 400;
            end else if (stretch == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    ready_phase = 1'b1;
                    stretch     = $urandom_range(1, 20);
                end else if (pick < 85) begin
                    ready_phase = 1'b0;
                    stretch     = $urandom_range(1, 3);
                end else if (pick < 95) begin
                    ready_phase = 1'b0;
                    stretch     = $urandom_range(8, 40);
                end else begin
                    ready_phase = 1'b1;
                    stretch     = $urandom_range(80, 200);
                end
            end
            m_tready <= ready_phase;
            stretch--;
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_word(
        logic [ENTRY_IDX_W-1:0] idx, logic [OWNER_W-1:0] e_owner, fdr_class_t e_cls,
        logic [DSCP_W-1:0] e_dscp, logic e_dv, logic [OWNER_W-1:0] f_owner,
        logic [TOS_W-1:0] tos, logic [PRIO_W-1:0] prio);
        return {7'd0, prio, tos, f_owner, e_dv, e_dscp, e_cls, e_owner, idx};
    endfunction

    // Present one word and hold it until accepted; valid stays high on return.
    task automatic send_word(fdr_op_t op, logic [S_TDATA_W-1:0] data);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid for a pause set by n, with junk on the data lines.
    task automatic sender_pause(int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom};
            s_tuser  <= 1'($urandom_range(0, 1));
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic put_entry(logic [ENTRY_IDX_W-1:0] idx, logic [OWNER_W-1:0] owner,
                             fdr_class_t cls, logic [DSCP_W-1:0] dscp, logic dv);
        send_word(OP_WRITE, pack_word(idx, owner, cls, dscp, dv, '0, '0, '0));
    endtask

    task automatic put_packet(logic [OWNER_W-1:0] owner, logic [TOS_W-1:0] tos,
                              logic [PRIO_W-1:0] prio);
        send_word(OP_CLASSIFY, pack_word('0, '0, CLS_FAST, '0, 1'b0, owner, tos, prio));
    endtask

    // Drop valid and wait until every pending result has come back.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
    endtask

    // Register write; only called while the row is empty.
    task automatic write_reg(fdr_cfg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Owner ids mostly come from a small pool so that matches are common.
    function automatic logic [OWNER_W-1:0] pick_owner(int pool_pct, int zero_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < pool_pct)
            return owner_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < pool_pct + zero_pct)
            return '0;
        return $urandom;
    endfunction

    task automatic send_random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (!burst_phase) begin
            if (pick < 65)
                sender_pause(0);
            else if (pick < 90)
                sender_pause($urandom_range(1, 3));
            else
                sender_pause($urandom_range(8, 40));
        end
        // Occasionally retire a pool id so stale table entries show up.
        if ($urandom_range(0, 49) == 0)
            owner_pool[$urandom_range(1, POOL_SIZE - 1)] = $urandom;
        // Fill the unused half of each word with noise.
        if ($urandom_range(0, 3) == 0)
            send_word(OP_WRITE, pack_word(4'($urandom_range(0, TABLE_DEPTH - 1)),
                      pick_owner(80, 10), fdr_class_t'($urandom_range(0, 3)),
                      6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), $urandom,
                      8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))));
        else
            send_word(OP_CLASSIFY, pack_word(4'($urandom_range(0, TABLE_DEPTH - 1)),
                      $urandom, fdr_class_t'($urandom_range(0, 3)),
                      6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                      pick_owner(75, 10), 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15))));
    endtask

    initial begin
        int pick;
        logic [CFG_DATA_W-1:0] count;
        tracker     = new();
        words_in    = 0;
        idle_cycles = 0;
        burst_phase = 1'b1;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_CLASSIFY;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_ENABLE;
        cfg_data    = '0;
        owner_pool[0] = 32'hFFFF_FFFF;
        for (int i = 1; i < POOL_SIZE; i++)
            owner_pool[i] = $urandom;

        // Hold reset low, then release it on a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Disabled after reset: packets pass, writes still load the table.
        put_packet(32'h0000_0001, 8'hFF, 4'd15);
        put_entry(4'd0, 32'hFFFF_FFFF, CLS_FAST, 6'h3F, 1'b1);
        put_packet(32'hFFFF_FFFF, 8'h00, 4'd0);
        settle();

        write_reg(CFG_ENABLE, 5'd1);
        write_reg(CFG_ACTIVE, 5'd16);
        // All-ones owner, TOS and priority extremes.
        put_packet(32'hFFFF_FFFF, 8'h00, 4'd0);
        put_packet(32'hFFFF_FFFF, 8'hFF, 4'd15);
        // One slot per class; slot 4 duplicates slot 1 and must lose.
        put_entry(4'd1, 32'h0000_00A5, CLS_MID, 6'h00, 1'b1);
        put_entry(4'd2, 32'h5A5A_0001, CLS_SLOW, 6'h2A, 1'b0);
        put_entry(4'd3, 32'h1234_5678, CLS_NONE, 6'h15, 1'b1);
        put_entry(4'd15, 32'h0BAD_F00D, CLS_FAST, 6'h3F, 1'b0);
        put_entry(4'd4, 32'h0000_00A5, CLS_FAST, 6'h3F, 1'b1);
        put_packet(32'h0000_00A5, 8'hFF, 4'd9);
        put_packet(32'h5A5A_0001, 8'h81, 4'd4);
        // Class none: priority kept, DSCP still rewritten.
        put_packet(32'h1234_5678, 8'h02, 4'd12);
        put_packet(32'h0BAD_F00D, 8'h40, 4'd3);
        // Owner zero and an unknown owner never match.
        put_packet(32'h0000_0000, 8'h55, 4'd5);
        put_packet(32'hDEAD_BEEF, 8'hAA, 4'd10);
        put_entry(4'd5, 32'h0000_0000, CLS_FAST, 6'h01, 1'b1);
        put_packet(32'h0000_0000, 8'h3C, 4'd6);
        settle();

        // No slots active.
        write_reg(CFG_ACTIVE, 5'd0);
        put_packet(32'h0000_00A5, 8'h11, 4'd2);
        settle();
        // Above table depth: clamps to all slots, so the last slot matches.
        write_reg(CFG_ACTIVE, 5'd31);
        put_packet(32'h0BAD_F00D, 8'h7E, 4'd8);
        settle();
        // Last slot just outside the window.
        write_reg(CFG_ACTIVE, 5'd15);
        put_packet(32'h0BAD_F00D, 8'h7E, 4'd8);
        put_packet(32'h1234_5678, 8'hC1, 4'd1);
        settle();
        write_reg(CFG_ACTIVE, 5'd1);
        put_packet(32'hFFFF_FFFF, 8'h5A, 4'd11);
        put_packet(32'h0000_00A5, 8'h5A, 4'd11);
        settle();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                write_reg(CFG_ENABLE, 5'd1);
                write_reg(CFG_ACTIVE, 5'd16);
            end else begin
                // Upper bits of the enable data are don't-care; toggle them anyway.
                write_reg(CFG_ENABLE, {4'($urandom_range(0, 15)),
                                       1'($urandom_range(0, 4) != 0)});
                pick = $urandom_range(0, 11);
                case (pick)
                    0:       count = 5'd0;
                    1:       count = 5'd1;
                    2:       count = 5'd15;
                    3:       count = 5'd16;
                    4:       count = 5'd17;
                    5:       count = 5'd31;
                    default: count = 5'($urandom_range(0, 31));
                endcase
                write_reg(CFG_ACTIVE, count);
            end
            // Some phases run with no sender gaps at all.
            burst_phase = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random_word();
            settle();
        end

        // Let the row drain fully, then report.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/fdr_pkg.sv
rtl/fdr_cell.sv
rtl/flow_priority_dscp_remarker.sv
dv/flow_priority_dscp_remarker_test.sv
